FILE: src/parallel_flash_command_engine_defines.svh
// Assertion macros for the parallel flash command engine.
// Included by the top level; no other dependencies.
`ifndef PARALLEL_FLASH_COMMAND_ENGINE_DEFINES_SVH
`define PARALLEL_FLASH_COMMAND_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define PFCE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("pfce assertion failed");
`define PFCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfce assertion failed");
`else
`define PFCE_ASSERT(lbl, clk, rst_n, prop)
`define PFCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/pfce_pkg.sv
// Shared types and constants for the parallel flash command engine.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pfce_pkg;

    // Array geometry
    localparam int SECTOR_BYTES = 16384;
    localparam int SECTOR_COUNT = 8;
    localparam int ARRAY_BYTES  = SECTOR_BYTES * SECTOR_COUNT;
    localparam int ADDR_W       = $clog2(ARRAY_BYTES);

    // Fixed port widths
    localparam int SECTOR_W   = 3;
    localparam int OFFSET_W   = 14;
    localparam int DATA_W     = 8;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int SEQ_ADDR_W = 11;

    // Command sequence addresses and data
    localparam logic [SEQ_ADDR_W-1:0] SEQ_ADDR_A = 11'h555;
    localparam logic [SEQ_ADDR_W-1:0] SEQ_ADDR_B = 11'h2AA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK1      = 8'hAA;
    localparam logic [DATA_W-1:0] CMD_UNLOCK2      = 8'h55;
    localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 8'h80;
    localparam logic [DATA_W-1:0] CMD_AUTOSELECT   = 8'h90;
    localparam logic [DATA_W-1:0] CMD_CHIP_ERASE   = 8'h10;
    localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;
    localparam logic [DATA_W-1:0] CMD_RESET        = 8'hF0;

    localparam logic [DATA_W-1:0] ERASED_BYTE   = 8'hFF;
    localparam logic [DATA_W-1:0] UNMAPPED_BYTE = 8'hFF;
    localparam logic [DATA_W-1:0] ZERO_BYTE     = 8'h00;
    localparam logic [DATA_W-1:0] PROTECT_NONE  = 8'h00;

    // Autoselect offsets
    localparam logic [7:0] AS_MANUF   = 8'h00;
    localparam logic [7:0] AS_DEVICE  = 8'h01;
    localparam logic [7:0] AS_PROTECT = 8'h02;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_MANUF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE = 2'd1;
    localparam logic [DATA_W-1:0] MANUF_RESET  = 8'h01;
    localparam logic [DATA_W-1:0] DEVICE_RESET = 8'h20;

    typedef enum logic [PHASE_W-1:0] {
        PH_READ = 3'd0,
        PH_C2   = 3'd1,
        PH_C3   = 3'd2,
        PH_C4   = 3'd3,
        PH_C5   = 3'd4,
        PH_C6   = 3'd5,
        PH_PROG = 3'd6,
        PH_AUTO = 3'd7
    } t_phase;

    typedef enum logic {
        ST_IDLE,
        ST_ERASE
    } t_state;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_ARRAY,
        RD_AUTO,
        RD_UNMAPPED
    } t_rd_sel;

    typedef struct packed {
        logic    accept;
        t_rd_sel rd_sel;
        logic    prog_we;
        logic    erase_start;
        logic    erase_chip;
        logic    erase_step;
        t_phase  phase_after;
    } t_dp_cmd;

    typedef struct packed {
        logic loc_ok;
        logic sec_ok;
        logic erase_done;
    } t_dp_stat;

endpackage

FILE: src/pfce_ctrl.sv
// Controller of the flash command engine: command phase and erase sequencing.
// Depends on pfce_pkg.
`timescale 1ns / 1ps

module pfce_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_mode,
    input  logic [pfce_pkg::SEQ_ADDR_W-1:0]     i_seq_addr,
    input  logic [pfce_pkg::DATA_W-1:0]         i_data,
    input  pfce_pkg::t_dp_stat                  i_stat,
    output logic                                o_busy,
    output pfce_pkg::t_dp_cmd                   o_cmd
);

    pfce_pkg::t_state r_state, n_state;
    pfce_pkg::t_phase r_phase, n_phase;
    pfce_pkg::t_phase wr_phase;
    logic             accept;
    logic             chip_go;
    logic             sec_go;
    logic             erase_go;

    assign accept   = i_start && (r_state == pfce_pkg::ST_IDLE);
    assign erase_go = chip_go || (sec_go && i_stat.sec_ok);

    // Phase a write would lead to
    always_comb begin
        wr_phase = r_phase;
        chip_go  = 1'b0;
        sec_go   = 1'b0;
        unique case (r_phase)
            pfce_pkg::PH_READ: begin
                if (i_seq_addr == pfce_pkg::SEQ_ADDR_A && i_data == pfce_pkg::CMD_UNLOCK1) begin
                    wr_phase = pfce_pkg::PH_C2;
                end
            end
            pfce_pkg::PH_C4: begin
                if (i_seq_addr == pfce_pkg::SEQ_ADDR_A && i_data == pfce_pkg::CMD_UNLOCK1) begin
                    wr_phase = pfce_pkg::PH_C5;
                end
            end
            pfce_pkg::PH_C2: begin
                if (i_seq_addr == pfce_pkg::SEQ_ADDR_B && i_data == pfce_pkg::CMD_UNLOCK2) begin
                    wr_phase = pfce_pkg::PH_C3;
                end
            end
            pfce_pkg::PH_C5: begin
                if (i_seq_addr == pfce_pkg::SEQ_ADDR_B && i_data == pfce_pkg::CMD_UNLOCK2) begin
                    wr_phase = pfce_pkg::PH_C6;
                end
            end
            pfce_pkg::PH_C3: begin
                if (i_seq_addr == pfce_pkg::SEQ_ADDR_A) begin
                    if (i_data == pfce_pkg::CMD_PROGRAM) begin
                        wr_phase = pfce_pkg::PH_PROG;
                    end else if (i_data == pfce_pkg::CMD_ERASE_SETUP) begin
                        wr_phase = pfce_pkg::PH_C4;
                    end else if (i_data == pfce_pkg::CMD_AUTOSELECT) begin
                        wr_phase = pfce_pkg::PH_AUTO;
                    end
                end
            end
            pfce_pkg::PH_C6: begin
                if (i_seq_addr == pfce_pkg::SEQ_ADDR_A && i_data == pfce_pkg::CMD_CHIP_ERASE) begin
                    chip_go  = 1'b1;
                    wr_phase = pfce_pkg::PH_READ;
                end else if (i_data == pfce_pkg::CMD_SECTOR_ERASE) begin
                    sec_go   = 1'b1;
                    wr_phase = pfce_pkg::PH_READ;
                end
            end
            pfce_pkg::PH_PROG: begin
                wr_phase = pfce_pkg::PH_READ;
            end
            pfce_pkg::PH_AUTO: begin
                wr_phase = pfce_pkg::PH_AUTO;
            end
            default: begin
                wr_phase = pfce_pkg::PH_READ;
            end
        endcase
        if (i_data == pfce_pkg::CMD_RESET) begin
            wr_phase = pfce_pkg::PH_READ;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            pfce_pkg::ST_IDLE: begin
                if (accept && i_mode) begin
                    n_phase = wr_phase;
                    if (erase_go) begin
                        n_state = pfce_pkg::ST_ERASE;
                    end
                end
            end
            pfce_pkg::ST_ERASE: begin
                if (i_stat.erase_done) begin
                    n_state = pfce_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pfce_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd             = '0;
        o_cmd.accept      = accept;
        o_cmd.phase_after = n_phase;
        o_busy            = 1'b0;
        unique case (r_state)
            pfce_pkg::ST_IDLE: begin
                if (i_mode) begin
                    o_cmd.rd_sel      = pfce_pkg::RD_ZERO;
                    o_cmd.prog_we     = accept && (r_phase == pfce_pkg::PH_PROG)
                                        && i_stat.loc_ok;
                    o_cmd.erase_start = accept && erase_go;
                    o_cmd.erase_chip  = chip_go;
                end else if (r_phase == pfce_pkg::PH_AUTO) begin
                    o_cmd.rd_sel = pfce_pkg::RD_AUTO;
                end else if (i_stat.loc_ok) begin
                    o_cmd.rd_sel = pfce_pkg::RD_ARRAY;
                end else begin
                    o_cmd.rd_sel = pfce_pkg::RD_UNMAPPED;
                end
            end
            pfce_pkg::ST_ERASE: begin
                o_busy           = 1'b1;
                o_cmd.erase_step = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfce_pkg::ST_IDLE;
            r_phase <= pfce_pkg::PH_READ;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

FILE: src/pfce_datapath.sv
// Datapath of the flash command engine: byte array, erase sweep counter,
// autoselect registers and result registers. Depends on pfce_pkg.
`timescale 1ns / 1ps

module pfce_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pfce_pkg::t_dp_cmd                   i_cmd,
    input  logic [pfce_pkg::SECTOR_W-1:0]       i_sector,
    input  logic [pfce_pkg::OFFSET_W-1:0]       i_offset,
    input  logic [pfce_pkg::DATA_W-1:0]         i_write_data,
    input  logic                                i_cfg_valid,
    input  logic [pfce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfce_pkg::DATA_W-1:0]         i_cfg_data,
    output logic                                o_cfg_ready,
    output pfce_pkg::t_dp_stat                  o_stat,
    output logic                                o_strobe,
    output logic [pfce_pkg::DATA_W-1:0]         o_read_data,
    output logic [pfce_pkg::PHASE_W-1:0]        o_phase_after
);

    localparam int AW = pfce_pkg::ADDR_W;

    logic [pfce_pkg::DATA_W-1:0] r_mem [pfce_pkg::ARRAY_BYTES];
    logic [pfce_pkg::DATA_W-1:0] r_mem_q;
    logic [AW-1:0]               r_erase_addr;
    logic [AW-1:0]               r_erase_last;
    logic [pfce_pkg::DATA_W-1:0] r_manuf;
    logic [pfce_pkg::DATA_W-1:0] r_device;
    logic                        r_strobe;
    logic                        r_use_mem;
    logic [pfce_pkg::DATA_W-1:0] r_byte;
    pfce_pkg::t_phase            r_phase;

    logic                        sec_ok;
    logic                        off_ok;
    logic [AW-1:0]               sec_base;
    logic [AW-1:0]               loc_addr;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [pfce_pkg::DATA_W-1:0] mem_wdata;
    logic [pfce_pkg::DATA_W-1:0] auto_byte;

    assign sec_ok   = 32'(i_sector) < 32'(pfce_pkg::SECTOR_COUNT);
    assign off_ok   = 32'(i_offset) < 32'(pfce_pkg::SECTOR_BYTES);
    assign sec_base = AW'(i_sector) * AW'(pfce_pkg::SECTOR_BYTES);
    assign loc_addr = sec_base + AW'(i_offset);

    assign o_stat.loc_ok     = sec_ok && off_ok;
    assign o_stat.sec_ok     = sec_ok;
    assign o_stat.erase_done = (r_erase_addr == r_erase_last);

    // Erase sweep wins the write port; program only happens when idle
    assign mem_we    = i_rst_n && (i_cmd.prog_we || i_cmd.erase_step);
    assign mem_waddr = i_cmd.erase_step ? r_erase_addr : loc_addr;
    assign mem_wdata = i_cmd.erase_step ? pfce_pkg::ERASED_BYTE : i_write_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_mem_q <= r_mem[loc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.erase_start) begin
            r_erase_addr <= i_cmd.erase_chip ? '0 : sec_base;
            r_erase_last <= i_cmd.erase_chip ? AW'(pfce_pkg::ARRAY_BYTES - 1)
                                             : sec_base + AW'(pfce_pkg::SECTOR_BYTES - 1);
        end else if (i_cmd.erase_step) begin
            r_erase_addr <= r_erase_addr + AW'(1);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manuf  <= pfce_pkg::MANUF_RESET;
            r_device <= pfce_pkg::DEVICE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pfce_pkg::CFG_MANUF:  r_manuf  <= i_cfg_data;
                pfce_pkg::CFG_DEVICE: r_device <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (i_offset[7:0])
            pfce_pkg::AS_MANUF:   auto_byte = r_manuf;
            pfce_pkg::AS_DEVICE:  auto_byte = r_device;
            pfce_pkg::AS_PROTECT: auto_byte = pfce_pkg::PROTECT_NONE;
            default:              auto_byte = pfce_pkg::UNMAPPED_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_phase   <= i_cmd.phase_after;
            r_use_mem <= (i_cmd.rd_sel == pfce_pkg::RD_ARRAY);
            unique case (i_cmd.rd_sel)
                pfce_pkg::RD_AUTO:     r_byte <= auto_byte;
                pfce_pkg::RD_UNMAPPED: r_byte <= pfce_pkg::UNMAPPED_BYTE;
                default:               r_byte <= pfce_pkg::ZERO_BYTE;
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_read_data   = r_use_mem ? r_mem_q : r_byte;
    assign o_phase_after = r_phase;

endmodule

FILE: src/parallel_flash_command_engine.sv
// Top level of the parallel flash command engine.
// Depends on pfce_pkg, pfce_ctrl, pfce_datapath and the assertion macro header.
`timescale 1ns / 1ps
`include "parallel_flash_command_engine_defines.svh"

// Bus-access front end of a parallel NOR flash. Each access is taken at a
// rising edge where start is high and busy is low, and it produces exactly
// one result beat: o_strobe is high for the one cycle right after the
// access, with o_read_data and o_phase_after valid in that cycle only. The
// receiver cannot stall, so sample the result on that strobe. Reads and
// writes may follow back to back. A chip erase or a sector erase raises
// busy in the same cycle as its result beat and keeps it high while the
// array's single write port fills the erased range with 0xFF, one byte per
// cycle, over one sector or over the whole chip. Reset clears the command
// phase, the erase state and the result strobe and reloads the autoselect
// codes; array contents stay undefined until programmed or erased. The
// configuration write port is always ready; write it only while no access
// is in flight.
module parallel_flash_command_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // access channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_mode,
    input  logic [pfce_pkg::SECTOR_W-1:0]       i_sector,
    input  logic [pfce_pkg::OFFSET_W-1:0]       i_offset,
    input  logic [pfce_pkg::DATA_W-1:0]         i_write_data,
    // result beat
    output logic                                o_strobe,
    output logic [pfce_pkg::DATA_W-1:0]         o_read_data,
    output logic [pfce_pkg::PHASE_W-1:0]        o_phase_after,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pfce_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfce_pkg::DATA_W-1:0]         i_cfg_data
);

    pfce_pkg::t_dp_cmd  dp_cmd;
    pfce_pkg::t_dp_stat dp_stat;

    // Command sequencing: tracks the unlock phase and owns busy
    pfce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_mode     (i_mode),
        .i_seq_addr (i_offset[pfce_pkg::SEQ_ADDR_W-1:0]),
        .i_data     (i_write_data),
        .i_stat     (dp_stat),
        .o_busy     (busy),
        .o_cmd      (dp_cmd)
    );

    // Array, erase sweep and result registers
    pfce_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_sector      (i_sector),
        .i_offset      (i_offset),
        .i_write_data  (i_write_data),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .o_stat        (dp_stat),
        .o_strobe      (o_strobe),
        .o_read_data   (o_read_data),
        .o_phase_after (o_phase_after)
    );

    // Every accepted access gives one result beat on the next cycle, and only then
    `PFCE_ASSERT_NEXT(a_accept_gives_beat, i_clk, i_rst_n, start && !busy, o_strobe)
    `PFCE_ASSERT_NEXT(a_no_stray_beat, i_clk, i_rst_n, !(start && !busy), !o_strobe)
    // An erase reports read mode in the beat that starts the sweep
    `PFCE_ASSERT(a_erase_beat_read_mode, i_clk, i_rst_n, $rose(busy) |-> (o_strobe && (o_phase_after == pfce_pkg::PH_READ)))
    // Writes return zero data
    `PFCE_ASSERT_NEXT(a_write_reads_zero, i_clk, i_rst_n, start && !busy && i_mode, o_read_data == pfce_pkg::ZERO_BYTE)

endmodule
